[hdl/nbody_gravity_step_defines.svh]
// Assertion helpers for the gravity step block.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef NBODY_GRAVITY_STEP_DEFINES_SVH
`define NBODY_GRAVITY_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define NBG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("nbg assertion failed");
`define NBG_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("nbg invariant violated");
`else
`define NBG_ASSERT(lbl, prop)
`define NBG_ASSERT_NEVER(lbl, expr)
`endif
`endif

[hdl/nbg_pkg.sv]
package nbg_pkg;

  localparam int unsigned MAX_BODIES_DEF = 64;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam logic [31:0] STEP_TIME_RST  = 32'h0001_0000;

  typedef enum logic [4:0] {
    S_LOAD, S_RDI, S_LATI, S_RDJ, S_CHKJ, S_SQ, S_SQSUM, S_ZCHK, S_SQRTW,
    S_DIV1, S_DIV1W, S_DIV2, S_DIV2W, S_PMUL, S_PDIV, S_PDIVW, S_NEXTJ,
    S_VMUL, S_VADD, S_XMUL, S_XADD, S_EMIT, S_OUT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_WRITE, OP_LATCH_I, OP_DIFF, OP_SQ, OP_SQSUM, OP_SQRT_GO,
    OP_DIV1_GO, OP_T1, OP_DIV2_GO, OP_T2, OP_PMUL, OP_DIV3_GO, OP_ACC,
    OP_VMUL, OP_VADD, OP_XMUL, OP_XADD, OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] axis;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] flags;     // {attracts_others, is_affected} of the word just read
    logic       s_zero;
    logic       unit_done;
  } dp_stat_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic        [31:0] body_mass;
    logic               is_affected;
    logic               attracts_others;
    logic               last_body;
  } body_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic               final_result;
  } result_t;

endpackage

[hdl/nbg_body_if.sv]
interface nbg_body_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic        [31:0] body_mass;
  logic               is_affected;
  logic               attracts_others;
  logic               last_body;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, body_mass,
           is_affected, attracts_others, last_body,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, body_mass,
           is_affected, attracts_others, last_body,
    output ready
  );
endinterface

[hdl/nbg_res_if.sv]
interface nbg_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_pos_z;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_vel_z;
  logic               final_result;

  modport source (
    output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
           final_result,
    input  ready
  );
  modport sink (
    input  valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
           final_result,
    output ready
  );
endinterface

[hdl/nbg_cfg_if.sv]
interface nbg_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] step_time;

  modport source (output valid, step_time, input ready);
  modport sink (input valid, step_time, output ready);
endinterface

[hdl/nbg_div.sv]
// Restoring divider, one quotient bit per cycle.
module nbg_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [63:0] quot_o,
  output logic        done_o
);

  logic [63:0] quo_q;
  logic [31:0] rem_q, dvs_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] rem_sh, rem_sub;
  logic        ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[63]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd63);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], ge};
      rem_q <= rem_sub[31:0];
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

[hdl/nbg_sqrt.sv]
// Bit-pair integer square root, 32 iterations.
module nbg_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o,
  output logic        done_o
);

  logic [63:0] n_q, r_q, bit_q, trial;
  logic        done_q, ge;

  always_comb begin
    trial = r_q + bit_q;
    ge    = n_q >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (bit_q == 64'd1);
      if (start_i)           bit_q <= 64'h4000_0000_0000_0000;
      else if (bit_q != '0)  bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= rad_i;
      r_q <= '0;
    end else if (bit_q != '0) begin
      if (ge) begin
        n_q <= n_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
    end
  end

  assign root_o = r_q[31:0];
  assign done_o = done_q;

endmodule

[hdl/nbg_datapath.sv]
module nbg_datapath #(
  parameter int unsigned MAX_BODIES = nbg_pkg::MAX_BODIES_DEF,
  parameter int unsigned FRAC_BITS  = nbg_pkg::FRAC_BITS_DEF,
  localparam int unsigned AW = $clog2(MAX_BODIES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nbg_pkg::dp_cmd_t  cmd_i,
  input  logic [AW-1:0]     addr_i,
  input  nbg_pkg::body_t    body_i,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_data_i,
  output nbg_pkg::dp_stat_t stat_o,
  output nbg_pkg::result_t  result_o
);

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [49:0] v);
    if (v > 50'sd2147483647)       return 32'h7fff_ffff;
    else if (v < -50'sd2147483648) return 32'h8000_0000;
    else                           return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(logic signed [49:0] v);
    if (v > 50'sh0_7fff_ffff_ffff)       return 48'h7fff_ffff_ffff;
    else if (v < -50'sh0_8000_0000_0000) return 48'h8000_0000_0000;
    else                                 return v[47:0];
  endfunction

  function automatic logic [31:0] satu32(logic [63:0] v);
    return (v > 64'h0000_0000_ffff_ffff) ? 32'hffff_ffff : v[31:0];
  endfunction

  // base + sign * (|v| * dt >> F), saturated
  function automatic logic signed [31:0] advance(logic signed [31:0] base, logic neg,
                                                 logic [63:0] prod);
    logic [63:0]        d;
    logic [33:0]        dd;
    logic signed [49:0] dv, sum;
    d   = prod >> FRAC_BITS;
    dd  = (d > 64'h2_0000_0000) ? 34'h2_0000_0000 : d[33:0];
    dv  = $signed({16'b0, dd});
    sum = neg ? (50'(base) - dv) : (50'(base) + dv);
    return sat32(sum);
  endfunction

  logic [95:0] pos_mem [MAX_BODIES];
  logic [95:0] vel_mem [MAX_BODIES];
  logic [31:0] mass_mem [MAX_BODIES];
  logic [1:0]  flag_mem [MAX_BODIES];

  logic [95:0] pos_rd_q, vel_rd_q;
  logic [31:0] mass_rd_q;
  logic [1:0]  flag_rd_q;

  logic signed [31:0] pi_q [3];
  logic signed [31:0] vi_q [3];
  logic signed [31:0] x_q [3];
  logic signed [47:0] acc_q [3];
  logic [31:0]        mass_j_q, t1_q, t2_q, step_time_q;
  logic [63:0]        s_q, prod_q;
  nbg_pkg::result_t   res_q;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        div_dividend, quot;
  logic [31:0]        root;
  logic               div_start, div_done, sqrt_done;
  logic signed [49:0] acc_ext, q_ext, acc_sum;
  logic [1:0]         ax;

  assign ax = cmd_i.axis;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == nbg_pkg::OP_WRITE) begin
      pos_mem[addr_i]  <= {body_i.pos_z, body_i.pos_y, body_i.pos_x};
      vel_mem[addr_i]  <= {body_i.vel_z, body_i.vel_y, body_i.vel_x};
      mass_mem[addr_i] <= body_i.body_mass;
      flag_mem[addr_i] <= {body_i.attracts_others, body_i.is_affected};
    end
    pos_rd_q  <= pos_mem[addr_i];
    vel_rd_q  <= vel_mem[addr_i];
    mass_rd_q <= mass_mem[addr_i];
    flag_rd_q <= flag_mem[addr_i];
  end

  // shared multiplier
  always_comb begin
    unique case (cmd_i.op)
      nbg_pkg::OP_SQ: begin
        mul_a = mag32(x_q[ax]);
        mul_b = mag32(x_q[ax]);
      end
      nbg_pkg::OP_PMUL: begin
        mul_a = t2_q;
        mul_b = mag32(x_q[ax]);
      end
      nbg_pkg::OP_VMUL: begin
        mul_a = mag32(sat32(50'(acc_q[ax])));
        mul_b = step_time_q;
      end
      nbg_pkg::OP_XMUL: begin
        mul_a = mag32(vi_q[ax]);
        mul_b = step_time_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b1;
    unique case (cmd_i.op)
      nbg_pkg::OP_DIV1_GO: div_dividend = 64'(mass_j_q) << FRAC_BITS;
      nbg_pkg::OP_DIV2_GO: div_dividend = 64'(t1_q) << FRAC_BITS;
      nbg_pkg::OP_DIV3_GO: div_dividend = prod_q;
      default: begin
        div_dividend = prod_q;
        div_start    = 1'b0;
      end
    endcase
  end

  // the quotient of a pull term never exceeds t2, so its low word is exact
  always_comb begin
    acc_ext = 50'(acc_q[ax]);
    q_ext   = $signed({18'b0, quot[31:0]});
    acc_sum = x_q[ax][31] ? (acc_ext - q_ext) : (acc_ext + q_ext);
  end

  nbg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (root),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  nbg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == nbg_pkg::OP_SQRT_GO),
    .rad_i   (s_q),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q <= nbg_pkg::STEP_TIME_RST;
      for (int k = 0; k < 3; k++) acc_q[k] <= '0;
    end else begin
      if (cfg_we_i) step_time_q <= cfg_data_i;
      if (cmd_i.op == nbg_pkg::OP_LATCH_I) begin
        for (int k = 0; k < 3; k++) acc_q[k] <= '0;
      end else if (cmd_i.op == nbg_pkg::OP_ACC) begin
        acc_q[ax] <= sat48(acc_sum);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (cmd_i.op)
      nbg_pkg::OP_LATCH_I: begin
        for (int k = 0; k < 3; k++) begin
          pi_q[k] <= $signed(pos_rd_q[32*k +: 32]);
          vi_q[k] <= $signed(vel_rd_q[32*k +: 32]);
        end
      end
      nbg_pkg::OP_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          x_q[k] <= sat32(50'(33'($signed(pos_rd_q[32*k +: 32])) - 33'(pi_q[k])));
        end
        mass_j_q <= mass_rd_q;
      end
      nbg_pkg::OP_SQ:    s_q <= (ax == 2'd0) ? '0 : (s_q + prod_q);
      nbg_pkg::OP_SQSUM: s_q <= s_q + prod_q;
      nbg_pkg::OP_T1:    t1_q <= satu32(quot);
      nbg_pkg::OP_T2:    t2_q <= satu32(quot);
      nbg_pkg::OP_VADD:  vi_q[ax] <= advance(vi_q[ax], acc_q[ax][47], prod_q);
      nbg_pkg::OP_XADD:  pi_q[ax] <= advance(pi_q[ax], vi_q[ax][31], prod_q);
      nbg_pkg::OP_EMIT: begin
        res_q.new_pos_x    <= pi_q[0];
        res_q.new_pos_y    <= pi_q[1];
        res_q.new_pos_z    <= pi_q[2];
        res_q.new_vel_x    <= vi_q[0];
        res_q.new_vel_y    <= vi_q[1];
        res_q.new_vel_z    <= vi_q[2];
        res_q.final_result <= cmd_i.last;
      end
      default: ;
    endcase
  end

  assign stat_o.flags     = flag_rd_q;
  assign stat_o.s_zero    = (s_q == '0);
  assign stat_o.unit_done = div_done | sqrt_done;
  assign result_o         = res_q;

endmodule

[hdl/nbg_ctrl.sv]
`include "nbody_gravity_step_defines.svh"

module nbg_ctrl #(
  parameter int unsigned MAX_BODIES = nbg_pkg::MAX_BODIES_DEF,
  localparam int unsigned AW = $clog2(MAX_BODIES),
  localparam int unsigned CW = $clog2(MAX_BODIES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  nbg_pkg::dp_stat_t stat_i,
  output nbg_pkg::dp_cmd_t  cmd_o,
  output logic [AW-1:0]     addr_o
);

  nbg_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d, n_q, n_d;
  logic [AW-1:0]   i_q, i_d, j_q, j_d;
  logic [1:0]      k_q, k_d;
  logic            i_last, j_last;

  assign i_last = (CW'(i_q) + CW'(1)) == n_q;
  assign j_last = (CW'(j_q) + CW'(1)) == n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nbg_pkg::S_LOAD;
      count_q <= '0;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    n_d     = n_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    unique case (state_q)
      nbg_pkg::S_LOAD: begin
        if (in_valid_i) begin
          // a full store closes the set as if marked last
          if (in_last_i || count_q == CW'(MAX_BODIES - 1)) begin
            n_d     = count_q + CW'(1);
            count_d = '0;
            i_d     = '0;
            state_d = nbg_pkg::S_RDI;
          end else begin
            count_d = count_q + CW'(1);
          end
        end
      end
      nbg_pkg::S_RDI:  state_d = nbg_pkg::S_LATI;
      nbg_pkg::S_LATI: begin
        if (stat_i.flags[0]) begin
          j_d     = '0;
          state_d = nbg_pkg::S_RDJ;
        end else begin
          state_d = nbg_pkg::S_EMIT;
        end
      end
      nbg_pkg::S_RDJ:  state_d = nbg_pkg::S_CHKJ;
      nbg_pkg::S_CHKJ: begin
        if (j_q == i_q || !stat_i.flags[1]) begin
          state_d = nbg_pkg::S_NEXTJ;
        end else begin
          k_d     = '0;
          state_d = nbg_pkg::S_SQ;
        end
      end
      nbg_pkg::S_SQ: begin
        k_d = k_q + 2'd1;
        if (k_q == 2'd2) state_d = nbg_pkg::S_SQSUM;
      end
      nbg_pkg::S_SQSUM: state_d = nbg_pkg::S_ZCHK;
      nbg_pkg::S_ZCHK:  state_d = stat_i.s_zero ? nbg_pkg::S_NEXTJ : nbg_pkg::S_SQRTW;
      nbg_pkg::S_SQRTW: if (stat_i.unit_done) state_d = nbg_pkg::S_DIV1;
      nbg_pkg::S_DIV1:  state_d = nbg_pkg::S_DIV1W;
      nbg_pkg::S_DIV1W: if (stat_i.unit_done) state_d = nbg_pkg::S_DIV2;
      nbg_pkg::S_DIV2:  state_d = nbg_pkg::S_DIV2W;
      nbg_pkg::S_DIV2W: begin
        if (stat_i.unit_done) begin
          k_d     = '0;
          state_d = nbg_pkg::S_PMUL;
        end
      end
      nbg_pkg::S_PMUL: state_d = nbg_pkg::S_PDIV;
      nbg_pkg::S_PDIV: state_d = nbg_pkg::S_PDIVW;
      nbg_pkg::S_PDIVW: begin
        if (stat_i.unit_done) begin
          k_d     = k_q + 2'd1;
          state_d = (k_q == 2'd2) ? nbg_pkg::S_NEXTJ : nbg_pkg::S_PMUL;
        end
      end
      nbg_pkg::S_NEXTJ: begin
        if (j_last) begin
          k_d     = '0;
          state_d = nbg_pkg::S_VMUL;
        end else begin
          j_d     = j_q + AW'(1);
          state_d = nbg_pkg::S_RDJ;
        end
      end
      nbg_pkg::S_VMUL: state_d = nbg_pkg::S_VADD;
      nbg_pkg::S_VADD: state_d = nbg_pkg::S_XMUL;
      nbg_pkg::S_XMUL: state_d = nbg_pkg::S_XADD;
      nbg_pkg::S_XADD: begin
        k_d     = k_q + 2'd1;
        state_d = (k_q == 2'd2) ? nbg_pkg::S_EMIT : nbg_pkg::S_VMUL;
      end
      nbg_pkg::S_EMIT: state_d = nbg_pkg::S_OUT;
      nbg_pkg::S_OUT: begin
        if (out_ready_i) begin
          if (i_last) begin
            state_d = nbg_pkg::S_LOAD;
          end else begin
            i_d     = i_q + AW'(1);
            state_d = nbg_pkg::S_RDI;
          end
        end
      end
      default: state_d = nbg_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cmd_o.op    = nbg_pkg::OP_NONE;
    cmd_o.axis  = k_q;
    cmd_o.last  = i_last;
    addr_o      = i_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      nbg_pkg::S_LOAD: begin
        in_ready_o = 1'b1;
        addr_o     = count_q[AW-1:0];
        if (in_valid_i) cmd_o.op = nbg_pkg::OP_WRITE;
      end
      nbg_pkg::S_RDJ:   addr_o   = j_q;
      nbg_pkg::S_LATI:  cmd_o.op = nbg_pkg::OP_LATCH_I;
      nbg_pkg::S_CHKJ:  cmd_o.op = nbg_pkg::OP_DIFF;
      nbg_pkg::S_SQ:    cmd_o.op = nbg_pkg::OP_SQ;
      nbg_pkg::S_SQSUM: cmd_o.op = nbg_pkg::OP_SQSUM;
      nbg_pkg::S_ZCHK:  if (!stat_i.s_zero) cmd_o.op = nbg_pkg::OP_SQRT_GO;
      nbg_pkg::S_DIV1:  cmd_o.op = nbg_pkg::OP_DIV1_GO;
      nbg_pkg::S_DIV1W: if (stat_i.unit_done) cmd_o.op = nbg_pkg::OP_T1;
      nbg_pkg::S_DIV2:  cmd_o.op = nbg_pkg::OP_DIV2_GO;
      nbg_pkg::S_DIV2W: if (stat_i.unit_done) cmd_o.op = nbg_pkg::OP_T2;
      nbg_pkg::S_PMUL:  cmd_o.op = nbg_pkg::OP_PMUL;
      nbg_pkg::S_PDIV:  cmd_o.op = nbg_pkg::OP_DIV3_GO;
      nbg_pkg::S_PDIVW: if (stat_i.unit_done) cmd_o.op = nbg_pkg::OP_ACC;
      nbg_pkg::S_VMUL:  cmd_o.op = nbg_pkg::OP_VMUL;
      nbg_pkg::S_VADD:  cmd_o.op = nbg_pkg::OP_VADD;
      nbg_pkg::S_XMUL:  cmd_o.op = nbg_pkg::OP_XMUL;
      nbg_pkg::S_XADD:  cmd_o.op = nbg_pkg::OP_XADD;
      nbg_pkg::S_EMIT:  cmd_o.op = nbg_pkg::OP_EMIT;
      nbg_pkg::S_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  `NBG_ASSERT(a_pair_distinct, (state_q == nbg_pkg::S_SQ) |-> (i_q != j_q))
  `NBG_ASSERT(a_emit_in_set, (state_q == nbg_pkg::S_OUT) |-> (CW'(i_q) < n_q))
  `NBG_ASSERT(a_set_closes, (state_q == nbg_pkg::S_OUT && out_ready_i && i_last) |=> (state_q == nbg_pkg::S_LOAD && count_q == '0))
  `NBG_ASSERT_NEVER(a_count_bound, count_q >= CW'(MAX_BODIES))

endmodule

[hdl/nbody_gravity_step.sv]
// Direct-sum gravity step over a set of bodies (G = 1, signed Q16.16).
// body_i: one request per body. The request with last_body set (or the one
// filling the store at MAX_BODIES) closes the set and starts the step; body_i
// is not ready again until every result of the set has been taken.
// result_o: one request per body in load order, final_result on the last one.
// cfg_i: writes step_time (dt, unsigned Q16.16); always ready, write only
// while idle.
// Loading accepts one body per cycle. After the set closes, each affected
// body visits every body of the set; each other attracting body at
// non-zero distance costs a 32-step root and five 64-step divisions on a
// single shared divider, so the work for a set of n bodies grows as n*n.
// Results wait in an output register; while result_o stalls the sequencer
// holds. Reset returns the sequencer to loading, empties the set and sets
// step_time to 1.0; the body stores themselves are not cleared.
module nbody_gravity_step #(
  parameter int unsigned MAX_BODIES = nbg_pkg::MAX_BODIES_DEF,
  parameter int unsigned FRAC_BITS  = nbg_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nbg_body_if.sink   body_i,
  nbg_res_if.source  result_o,
  nbg_cfg_if.sink    cfg_i
);

  localparam int unsigned AW = $clog2(MAX_BODIES);

  nbg_pkg::dp_cmd_t  cmd;
  nbg_pkg::dp_stat_t stat;
  nbg_pkg::body_t    body;
  nbg_pkg::result_t  res;
  logic [AW-1:0]     addr;

  assign body.pos_x           = body_i.pos_x;
  assign body.pos_y           = body_i.pos_y;
  assign body.pos_z           = body_i.pos_z;
  assign body.vel_x           = body_i.vel_x;
  assign body.vel_y           = body_i.vel_y;
  assign body.vel_z           = body_i.vel_z;
  assign body.body_mass       = body_i.body_mass;
  assign body.is_affected     = body_i.is_affected;
  assign body.attracts_others = body_i.attracts_others;
  assign body.last_body       = body_i.last_body;

  assign cfg_i.ready = 1'b1;

  nbg_ctrl #(
    .MAX_BODIES (MAX_BODIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (body_i.valid),
    .in_last_i   (body.last_body),
    .in_ready_o  (body_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .addr_o      (addr)
  );

  nbg_datapath #(
    .MAX_BODIES (MAX_BODIES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .addr_i     (addr),
    .body_i     (body),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.step_time),
    .stat_o     (stat),
    .result_o   (res)
  );

  assign result_o.new_pos_x    = res.new_pos_x;
  assign result_o.new_pos_y    = res.new_pos_y;
  assign result_o.new_pos_z    = res.new_pos_z;
  assign result_o.new_vel_x    = res.new_vel_x;
  assign result_o.new_vel_y    = res.new_vel_y;
  assign result_o.new_vel_z    = res.new_vel_z;
  assign result_o.final_result = res.final_result;

endmodule

[tb/nbody_gravity_step_test.sv]
`timescale 1ns / 100ps

module nbody_gravity_step_test;

  localparam int unsigned NBODIES  = nbg_pkg::MAX_BODIES_DEF;
  localparam int unsigned FRAC     = nbg_pkg::FRAC_BITS_DEF;
  localparam longint      S32_HI   = 64'sd2147483647;
  localparam longint      S32_LO   = -64'sd2147483648;
  localparam longint      S48_HI   = 64'sh7FFF_FFFF_FFFF;
  localparam longint      S48_LO   = -64'sh8000_0000_0000;
  localparam logic [31:0] DT_ONE   = nbg_pkg::STEP_TIME_RST;
  localparam int          WD_LIMIT = 150000;
  localparam int          RANDOM_ITEMS = 27;

  class gravity_scoreboard;
    nbg_pkg::body_t   bodies[$];
    nbg_pkg::result_t expected_bodies[$];
    logic [31:0] step_time = DT_ONE;
    int          errors = 0;

    function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [63:0] mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // base + v*dt, product truncated toward zero
    function automatic longint advance(longint base, longint v);
      logic [63:0] d;
      longint dd;
      d  = (mag(v) * {32'd0, step_time}) >> FRAC;
      dd = (d > (64'd1 << 33)) ? (64'sd1 <<< 33) : longint'(d);
      return clamp(v < 0 ? base - dd : base + dd, S32_LO, S32_HI);
    endfunction

    function automatic void body_pos(int i, output longint p[3]);
      p[0] = bodies[i].pos_x;
      p[1] = bodies[i].pos_y;
      p[2] = bodies[i].pos_z;
    endfunction

    function automatic void pull_on(int i, output longint acc[3]);
      longint pi[3], pj[3], x[3], pull;
      logic [63:0] s, span, t1, t2;
      body_pos(i, pi);
      acc = '{0, 0, 0};
      foreach (bodies[j]) begin
        if (j == i || !bodies[j].attracts_others) continue;
        body_pos(j, pj);
        s = 0;
        for (int k = 0; k < 3; k++) begin
          x[k] = clamp(pj[k] - pi[k], S32_LO, S32_HI);
          s += mag(x[k]) * mag(x[k]);
        end
        if (s == 0) continue;
        span = isqrt(s);
        t1 = ({32'd0, bodies[j].body_mass} << FRAC) / span;
        if (t1 > 64'hFFFF_FFFF) t1 = 64'hFFFF_FFFF;
        t2 = (t1 << FRAC) / span;
        if (t2 > 64'hFFFF_FFFF) t2 = 64'hFFFF_FFFF;
        for (int k = 0; k < 3; k++) begin
          pull = longint'((t2 * mag(x[k])) / span);
          acc[k] = clamp(x[k] < 0 ? acc[k] - pull : acc[k] + pull, S48_LO, S48_HI);
        end
      end
    endfunction

    function automatic void run_step();
      longint p[3], v[3], acc[3], nv[3], np[3];
      nbg_pkg::result_t r;
      foreach (bodies[i]) begin
        body_pos(i, p);
        v[0] = bodies[i].vel_x;
        v[1] = bodies[i].vel_y;
        v[2] = bodies[i].vel_z;
        if (bodies[i].is_affected) begin
          pull_on(i, acc);
          for (int k = 0; k < 3; k++) begin
            nv[k] = advance(v[k], clamp(acc[k], S32_LO, S32_HI));
            np[k] = advance(p[k], nv[k]);
          end
        end else begin
          nv = v;
          np = p;
        end
        r.new_pos_x = np[0][31:0];
        r.new_pos_y = np[1][31:0];
        r.new_pos_z = np[2][31:0];
        r.new_vel_x = nv[0][31:0];
        r.new_vel_y = nv[1][31:0];
        r.new_vel_z = nv[2][31:0];
        r.final_result = (i == bodies.size() - 1);
        expected_bodies.push_back(r);
      end
      bodies.delete();
    endfunction

    function automatic void note_body(nbg_pkg::body_t b);
      bodies.push_back(b);
      if (b.last_body || bodies.size() >= NBODIES) run_step();
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h, want %h", what, got, want);
    endtask

    task automatic check_result(nbg_pkg::result_t r);
      nbg_pkg::result_t e;
      if (expected_bodies.size() == 0) begin
        report("unexpected result", r.new_pos_x, 0);
        return;
      end
      e = expected_bodies.pop_front();
      if (r.new_pos_x !== e.new_pos_x) report("new_pos_x", r.new_pos_x, e.new_pos_x);
      if (r.new_pos_y !== e.new_pos_y) report("new_pos_y", r.new_pos_y, e.new_pos_y);
      if (r.new_pos_z !== e.new_pos_z) report("new_pos_z", r.new_pos_z, e.new_pos_z);
      if (r.new_vel_x !== e.new_vel_x) report("new_vel_x", r.new_vel_x, e.new_vel_x);
      if (r.new_vel_y !== e.new_vel_y) report("new_vel_y", r.new_vel_y, e.new_vel_y);
      if (r.new_vel_z !== e.new_vel_z) report("new_vel_z", r.new_vel_z, e.new_vel_z);
      if (r.final_result !== e.final_result)
        report("final_result", r.final_result, e.final_result);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nbg_body_if body_bus();
  nbg_res_if  res_bus();
  nbg_cfg_if  cfg_bus();

  nbody_gravity_step u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .body_i   (body_bus),
    .result_o (res_bus),
    .cfg_i    (cfg_bus)
  );

  gravity_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  int hold_off  = 0;
  int quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    body_bus.valid = 1'b0;
    body_bus.pos_x = '0;
    body_bus.pos_y = '0;
    body_bus.pos_z = '0;
    body_bus.vel_x = '0;
    body_bus.vel_y = '0;
    body_bus.vel_z = '0;
    body_bus.body_mass = '0;
    body_bus.is_affected = 1'b0;
    body_bus.attracts_others = 1'b0;
    body_bus.last_body = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.step_time = '0;
    res_bus.ready = 1'b0;
  end

  // result side: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_off > 0) begin
      res_bus.ready = 1'b0;
      hold_off--;
    end else begin
      res_bus.ready = ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) begin
      nbg_pkg::result_t r;
      r.new_pos_x = res_bus.new_pos_x;
      r.new_pos_y = res_bus.new_pos_y;
      r.new_pos_z = res_bus.new_pos_z;
      r.new_vel_x = res_bus.new_vel_x;
      r.new_vel_y = res_bus.new_vel_y;
      r.new_vel_z = res_bus.new_vel_z;
      r.final_result = res_bus.final_result;
      sb.check_result(r);
    end
  end

  always @(posedge clk) begin
    if ((body_bus.valid && body_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready) || hold_off > 0 || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("nbody_gravity_step_test: done, errors");
        $finish;
      end
    end
  end

  task automatic send_body(nbg_pkg::body_t b);
    while ($urandom_range(99) < send_idle) begin
      body_bus.valid = 1'b0;
      @(negedge clk);
    end
    body_bus.pos_x = b.pos_x;
    body_bus.pos_y = b.pos_y;
    body_bus.pos_z = b.pos_z;
    body_bus.vel_x = b.vel_x;
    body_bus.vel_y = b.vel_y;
    body_bus.vel_z = b.vel_z;
    body_bus.body_mass = b.body_mass;
    body_bus.is_affected = b.is_affected;
    body_bus.attracts_others = b.attracts_others;
    body_bus.last_body = b.last_body;
    body_bus.valid = 1'b1;
    do @(posedge clk); while (!body_bus.ready);
    sb.note_body(b);
    @(negedge clk);
    body_bus.valid = 1'b0;
  endtask

  task automatic drain();
    body_bus.valid = 1'b0;
    while (sb.expected_bodies.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_step_time(logic [31:0] dt);
    drain();
    cfg_bus.step_time = dt;
    cfg_bus.valid = 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.step_time = dt;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  function automatic logic [31:0] coord(bit near);
    return near ? $urandom_range(0, 32'h0014_0000) - 32'h000A_0000 : $urandom;
  endfunction

  function automatic nbg_pkg::body_t random_body(bit near, bit last);
    nbg_pkg::body_t b;
    b.pos_x = coord(near);
    b.pos_y = coord(near);
    b.pos_z = coord(near);
    b.vel_x = coord(near);
    b.vel_y = coord(near);
    b.vel_z = coord(near);
    b.body_mass = near ? $urandom_range(0, 32'h0040_0000) : $urandom;
    b.is_affected = $urandom_range(1);
    b.attracts_others = $urandom_range(1);
    b.last_body = last;
    return b;
  endfunction

  function automatic nbg_pkg::body_t make_body(logic [31:0] px, logic [31:0] py,
                                               logic [31:0] pz, logic [31:0] vx,
                                               logic [31:0] m,
                                               bit aff, bit att, bit last);
    nbg_pkg::body_t b;
    b.pos_x = px;
    b.pos_y = py;
    b.pos_z = pz;
    b.vel_x = vx;
    b.vel_y = -vx;
    b.vel_z = vx >>> 1;
    b.body_mass = m;
    b.is_affected = aff;
    b.attracts_others = att;
    b.last_body = last;
    return b;
  endfunction

  task automatic random_set(int n);
    bit near;
    near = $urandom_range(3) != 0;
    for (int i = 0; i < n; i++) send_body(random_body(near, i == n - 1));
  endtask

  initial begin
    int sent;
    nbg_pkg::body_t b;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // lone affected body: no pull, moves by v*dt
    send_body(make_body(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'hFFFF_FFFF,
                        1, 1, 1));
    // two bodies at the same spot
    send_body(make_body(32'h0001_0000, 0, 0, 32'h0000_8000, 32'h0010_0000, 1, 1, 0));
    send_body(make_body(32'h0001_0000, 0, 0, 32'h7FFF_FFFF, 32'h0010_0000, 1, 1, 1));
    // opposite corners: differences saturate
    send_body(make_body(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 32'hFFFF_FFFF,
                        1, 1, 0));
    send_body(make_body(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF,
                        1, 1, 1));
    // very close heavy pair: terms clip, velocity saturates
    send_body(make_body(0, 0, 0, 32'h7FFF_0000, 32'hFFFF_FFFF, 1, 1, 0));
    send_body(make_body(1, 0, 0, 32'h8001_0000, 32'hFFFF_FFFF, 1, 1, 0));
    // bystanders: neither pulled nor pulling, then pulled only
    send_body(make_body(32'h0003_0000, 32'hFFFD_0000, 1, 32'h0001_0000, 32'h0002_0000,
                        0, 0, 0));
    send_body(make_body(32'hFFFF_0000, 32'h0002_0000, 0, 32'hFFFF_8000, 0, 1, 0, 1));
    // plain non-attracting, unaffected set
    send_body(make_body(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                        32'h5555_5555, 0, 0, 1));

    write_step_time(0);
    random_set(3);
    write_step_time(32'hFFFF_FFFF);
    random_set(3);
    write_step_time(32'h0000_0001);
    random_set(2);

    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 36 : (phase == 1) ? 55 : 0;
      recv_idle = (phase == 0) ? 55 : (phase == 1) ? 36 : 0;
      write_step_time($urandom_range(32'h0000_1000, 32'h0002_0000));
      if (phase == 1) begin
        // set overflow: the 64th body starts the step without last_body
        for (int i = 0; i < NBODIES; i++) begin
          b = random_body(1, 0);
          b.attracts_others = (i < 2);
          send_body(b);
        end
        sent += NBODIES;
      end
      if (phase == 2) begin
        // results back up while bodies keep coming
        hold_off = 8000;
        random_set(5);
        random_set(4);
        sent += 9;
      end
      while (sent < (phase + 1) * (RANDOM_ITEMS / 3) + (phase == 1 ? NBODIES : 0) +
             (phase == 2 ? NBODIES : 0)) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 4);
        random_set(n);
        sent += n;
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("nbody_gravity_step_test: done, clean");
    end else begin
      $display("nbody_gravity_step_test: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/nbg_pkg.sv
hdl/nbg_body_if.sv
hdl/nbg_res_if.sv
hdl/nbg_cfg_if.sv
hdl/nbg_div.sv
hdl/nbg_sqrt.sv
hdl/nbg_datapath.sv
hdl/nbg_ctrl.sv
hdl/nbody_gravity_step.sv
tb/nbody_gravity_step_test.sv
